// ===== rtl/kplc_pkg.sv =====
// Shared types, codes and constants for the keypad code lock.
package kplc_pkg;

    // Internal mode register, one-hot
    typedef enum logic [3:0] {
        MODE_STANDBY = 4'b0001,
        MODE_AUTH    = 4'b0010,
        MODE_MENU    = 4'b0100,
        MODE_LOCKOUT = 4'b1000
    } mode_t;

    // Mode as reported on the result stream
    localparam logic [1:0] MODE_CODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_CODE_AUTH    = 2'd1;
    localparam logic [1:0] MODE_CODE_MENU    = 2'd2;
    localparam logic [1:0] MODE_CODE_LOCKOUT = 2'd3;

    // Event kinds
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_KEY  = 2'd1;
    localparam logic [1:0] OP_WAKE = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_NONE  = 2'd0;
    localparam logic [1:0] VERDICT_GRANT = 2'd1;
    localparam logic [1:0] VERDICT_WRONG = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIN_CODE     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS = 1'b1;

    // Keypad characters
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_0    = 8'h30;
    localparam logic [7:0] KEY_1    = 8'h31;
    localparam logic [7:0] KEY_9    = 8'h39;

    // Field widths
    localparam int unsigned PIN_W     = 16;
    localparam int unsigned TRIES_W   = 4;
    localparam int unsigned PHASE_W   = 6;
    localparam int unsigned HALL_W    = 4;
    localparam int unsigned KEY_W     = 8;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    // Timing in ticks
    localparam logic [PHASE_W-1:0] BLINK_ON_TICKS = 6'd10;
    localparam logic [PHASE_W-1:0] BLINK_PERIOD   = 6'd40;
    localparam logic [PHASE_W-1:0] ALARM_HALF     = 6'd10;
    localparam logic [PHASE_W-1:0] ALARM_TOTAL    = 6'd60;

    // Reset values and limits
    localparam logic [PIN_W-1:0]   PIN_RESET          = 16'h1234;
    localparam logic [TRIES_W-1:0] MAX_ATTEMPTS_RESET = 4'd3;
    localparam logic [TRIES_W-1:0] TRIES_MAX          = 4'd15;
    localparam int unsigned        CODE_DIGITS_DEFAULT = 4;

    // Result of one event
    typedef struct packed {
        logic [1:0]        mode;
        logic              white_led;
        logic              green_led;
        logic              red_led;
        logic              buzzer;
        logic              digit_taken;
        logic [1:0]        verdict;
        logic [HALL_W-1:0] hall_toggle;
        logic              logged_out;
    } kplc_result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        c = MODE_CODE_STANDBY;
        unique case (m)
            MODE_STANDBY: c = MODE_CODE_STANDBY;
            MODE_AUTH:    c = MODE_CODE_AUTH;
            MODE_MENU:    c = MODE_CODE_MENU;
            MODE_LOCKOUT: c = MODE_CODE_LOCKOUT;
            default:      c = MODE_CODE_STANDBY;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/keypad_pin_lock_controller.sv =====
// Top level of the keypad code lock: stream ports, configuration and pipeline registers.
//
// Keypad code lock. Each input transaction is one event: a 100 ms tick, a keypad key
// (ASCII) or a wake button press; each event returns exactly one result transaction
// carrying the mode, the LED and buzzer levels after the event, and the per-event
// flags (digit taken, PIN verdict, hall light toggle, logout). Standby blinks the
// white LED 10 ticks on, 30 off; a wake press starts PIN entry with the green LED
// lit; CODE_DIGITS decimal digits are compared with the BCD pin_code register. A
// match opens the menu ('#' logs out, '1'..'9' report a hall light). After
// max_attempts misses the lock sounds red LED and buzzer 10 on / 10 off three times,
// then drops to standby. Throughput is one event per clock cycle while the
// master side is not stalled. An accepted event is held in the input register,
// then passes through the combinational state update into the result register,
// which drives the master side. A stalled result holds the pipeline; the slave
// side keeps accepting as long as the input register can move on. Write
// configuration only while no event is in flight; cfg_ready is always high.
module keypad_pin_lock_controller #(
    parameter int unsigned CODE_DIGITS = kplc_pkg::CODE_DIGITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Event stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kplc_pkg::S_TDATA_W-1:0]      s_tdata,  // [7:0] key
    input  logic [kplc_pkg::OP_W-1:0]           s_tuser,  // [1:0] op
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] mode, [2] white_led, [3] green_led, [4] red_led, [5] buzzer,
    // [6] digit_taken, [8:7] verdict, [12:9] hall_toggle, [13] logged_out, [15:14] zero
    output logic [kplc_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kplc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kplc_pkg::PIN_W-1:0]          cfg_data
);
    import kplc_pkg::*;

    // Configuration registers
    logic [PIN_W-1:0]   pin_code_reg;
    logic [TRIES_W-1:0] max_attempts_reg;

    // Input stage
    logic               in_valid_reg, in_valid_next;
    logic [OP_W-1:0]    in_op_reg;
    logic [KEY_W-1:0]   in_key_reg;

    // Result stage
    logic               out_valid_reg, out_valid_next;
    kplc_result_t       out_res_reg;
    kplc_result_t       step_res;

    logic               s_fire;
    logic               advance;

    // Move the held event into the result stage when the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes: the user must send these only while the block is idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_code_reg     <= PIN_RESET;
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PIN_CODE:     pin_code_reg     <= cfg_data;
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[TRIES_W-1:0];
                default:          pin_code_reg     <= pin_code_reg;
            endcase
        end
    end

    // Input register: load on every accepted transaction, drop once it advances
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg  <= s_tuser;
            in_key_reg <= s_tdata[KEY_W-1:0];
        end
    end

    // State update and result for the event in the input register
    kplc_fsm #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .op           (in_op_reg),
        .key          (in_key_reg),
        .pin_code     (pin_code_reg),
        .max_attempts (max_attempts_reg),
        .res          (step_res)
    );

    // Result register: hold until the downstream takes it
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.logged_out,
                       out_res_reg.hall_toggle,
                       out_res_reg.verdict,
                       out_res_reg.digit_taken,
                       out_res_reg.buzzer,
                       out_res_reg.red_led,
                       out_res_reg.green_led,
                       out_res_reg.white_led,
                       out_res_reg.mode};

endmodule

// ===== rtl/kplc_fsm.sv =====
// Lock state registers and the per-event transition and result logic.
module kplc_fsm #(
    parameter int unsigned CODE_DIGITS = kplc_pkg::CODE_DIGITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  logic [kplc_pkg::OP_W-1:0]       op,
    input  logic [kplc_pkg::KEY_W-1:0]      key,
    input  logic [kplc_pkg::PIN_W-1:0]      pin_code,
    input  logic [kplc_pkg::TRIES_W-1:0]    max_attempts,
    output kplc_pkg::kplc_result_t          res
);
    import kplc_pkg::*;

    localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);
    localparam logic [PIN_W-1:0] CMP_MASK = (CODE_DIGITS >= 4) ? 16'hFFFF :
        PIN_W'((32'd1 << (4 * CODE_DIGITS)) - 32'd1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS);

    mode_t              mode_reg,   mode_next;
    logic [CNT_W-1:0]   digits_reg, digits_next;
    logic [PIN_W-1:0]   entry_reg,  entry_next;
    logic [TRIES_W-1:0] tries_reg,  tries_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;

    logic               digit_taken;
    logic [1:0]         verdict;
    logic [HALL_W-1:0]  hall;
    logic               logged_out;

    logic [PHASE_W-1:0] phase_inc;
    logic [CNT_W-1:0]   digits_inc;
    logic [PIN_W-1:0]   entry_shift;
    logic [TRIES_W-1:0] tries_inc;
    logic               is_digit;
    logic               is_hall_key;
    logic               alarm_on;

    assign phase_inc   = phase_reg + 1'b1;
    assign digits_inc  = digits_reg + 1'b1;
    assign entry_shift = {entry_reg[PIN_W-5:0], key[3:0]};
    assign tries_inc   = (tries_reg == TRIES_MAX) ? tries_reg : tries_reg + 1'b1;
    assign is_digit    = (key >= KEY_0) && (key <= KEY_9);
    assign is_hall_key = (key >= KEY_1) && (key <= KEY_9);

    always_comb begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        entry_next  = entry_reg;
        tries_next  = tries_reg;
        phase_next  = phase_reg;
        digit_taken = 1'b0;
        verdict     = VERDICT_NONE;
        hall        = '0;
        logged_out  = 1'b0;
        unique case (mode_reg)
            MODE_STANDBY: begin
                if (op == OP_TICK) begin
                    phase_next = (phase_inc >= BLINK_PERIOD) ? '0 : phase_inc;
                end else if (op == OP_WAKE) begin
                    mode_next   = MODE_AUTH;
                    digits_next = '0;
                    entry_next  = '0;
                    tries_next  = '0;
                    phase_next  = '0;
                end
            end
            MODE_AUTH: begin
                if (op == OP_KEY && is_digit) begin
                    digit_taken = 1'b1;
                    entry_next  = entry_shift;
                    digits_next = digits_inc;
                    if (digits_inc >= CNT_LAST) begin
                        digits_next = '0;
                        entry_next  = '0;
                        if ((entry_shift & CMP_MASK) == (pin_code & CMP_MASK)) begin
                            verdict   = VERDICT_GRANT;
                            mode_next = MODE_MENU;
                        end else begin
                            verdict    = VERDICT_WRONG;
                            tries_next = tries_inc;
                            if (tries_inc >= max_attempts) begin
                                mode_next  = MODE_LOCKOUT;
                                phase_next = '0;
                            end
                        end
                    end
                end
            end
            MODE_MENU: begin
                if (op == OP_KEY) begin
                    if (key == KEY_HASH) begin
                        logged_out = 1'b1;
                        mode_next  = MODE_STANDBY;
                        phase_next = '0;
                    end else if (is_hall_key) begin
                        hall = key[HALL_W-1:0];
                    end
                end
            end
            MODE_LOCKOUT: begin
                if (op == OP_TICK) begin
                    phase_next = phase_inc;
                    if (phase_inc >= ALARM_TOTAL) begin
                        mode_next  = MODE_STANDBY;
                        phase_next = '0;
                    end
                end
            end
            default: begin
                mode_next  = MODE_STANDBY;
                phase_next = '0;
            end
        endcase
    end

    // Alarm light is on in the first half of each 20-tick window
    assign alarm_on = (phase_next < ALARM_HALF) ||
                      (phase_next >= 6'd20 && phase_next < 6'd30) ||
                      (phase_next >= 6'd40 && phase_next < 6'd50) ||
                      (phase_next >= ALARM_TOTAL);

    always_comb begin
        res.mode        = mode_code(mode_next);
        res.white_led   = (mode_next == MODE_STANDBY) && (phase_next < BLINK_ON_TICKS);
        res.green_led   = (mode_next == MODE_AUTH) || (mode_next == MODE_MENU);
        res.red_led     = (mode_next == MODE_LOCKOUT) && alarm_on;
        res.buzzer      = (mode_next == MODE_LOCKOUT) && alarm_on;
        res.digit_taken = digit_taken;
        res.verdict     = verdict;
        res.hall_toggle = hall;
        res.logged_out  = logged_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_STANDBY;
            digits_reg <= '0;
            entry_reg  <= '0;
            tries_reg  <= '0;
            phase_reg  <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            entry_reg  <= entry_next;
            tries_reg  <= tries_next;
            phase_reg  <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_digits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        digits_reg < CNT_LAST)
        else $error("digit count reached code length");

    a_standby_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STANDBY) |-> (phase_reg < BLINK_PERIOD))
        else $error("standby blink phase out of range");

    a_lockout_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_LOCKOUT) |-> (phase_reg < ALARM_TOTAL))
        else $error("lockout phase out of range");

    a_grant_opens_menu: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.verdict == VERDICT_GRANT) |=> (mode_reg == MODE_MENU))
        else $error("granted entry did not open the menu");

    a_logout_to_standby: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.logged_out) |=> (mode_reg == MODE_STANDBY && phase_reg == '0))
        else $error("logout did not return to standby");
`endif

endmodule

// ===== test/keypad_pin_lock_controller_tb.sv =====
// Self-checking testbench for the keypad code lock: event stream in, one result per event.
module keypad_pin_lock_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kplc_pkg::*;

    localparam int unsigned LOCK_DIGITS  = 4;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // Two register stages between acceptance and result; leave some margin.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Event kind with no meaning; the lock must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Clock and DUT ports; every input starts at a known level.
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [7:0] key
    logic [OP_W-1:0]        s_tuser   = '0;   // [1:0] op
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [1:0] mode, [2] white_led, [3] green_led, [4] red_led, [5] buzzer,
    // [6] digit_taken, [8:7] verdict, [12:9] hall_toggle, [13] logged_out, [15:14] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PIN_W-1:0]       cfg_data  = '0;

    keypad_pin_lock_controller #(
        .CODE_DIGITS(LOCK_DIGITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the lock: registers and state after every accepted event.
    // ------------------------------------------------------------------
    logic [PIN_W-1:0]   cfg_pin       = PIN_RESET;
    logic [TRIES_W-1:0] cfg_max_tries = MAX_ATTEMPTS_RESET;
    logic [1:0]         lock_mode     = MODE_CODE_STANDBY;
    int unsigned        lock_digits   = 0;
    logic [PIN_W-1:0]   lock_entry    = '0;
    logic [TRIES_W-1:0] lock_tries    = '0;
    logic [PHASE_W-1:0] lock_phase    = '0;

    kplc_result_t   expected_lock_outputs[$];
    logic [7:0]     pending_digits[$];     // keys still to type for the current PIN entry
    int unsigned    fail_count  = 0;
    int unsigned    cycle_count = 0;
    int unsigned    burst_left  = 0;

    // Apply one event to the shadow lock and return the outputs it must produce.
    // 'acted' is low when the lock ignores the event altogether.
    function automatic kplc_result_t advance_lock(input logic [1:0] op, input logic [7:0] key,
                                                  output bit acted);
        kplc_result_t     res;
        logic [PIN_W-1:0] mask;
        res   = '0;
        acted = 1'b0;
        mask  = (LOCK_DIGITS >= 4) ? 16'hFFFF : PIN_W'((32'd1 << (4 * LOCK_DIGITS)) - 1);
        case (lock_mode)
            MODE_CODE_STANDBY: begin
                if (op == OP_TICK) begin
                    acted      = 1'b1;
                    lock_phase = lock_phase + 1'b1;
                    if (lock_phase >= BLINK_PERIOD)
                        lock_phase = '0;
                end else if (op == OP_WAKE) begin
                    // wake clears the entry and the miss count
                    acted       = 1'b1;
                    lock_mode   = MODE_CODE_AUTH;
                    lock_digits = 0;
                    lock_entry  = '0;
                    lock_tries  = '0;
                    lock_phase  = '0;
                end
            end
            MODE_CODE_AUTH: begin
                if (op == OP_KEY && key >= KEY_0 && key <= KEY_9) begin
                    acted           = 1'b1;
                    res.digit_taken = 1'b1;
                    lock_entry      = {lock_entry[PIN_W-5:0], 4'(key - KEY_0)};
                    lock_digits++;
                    if (lock_digits >= LOCK_DIGITS) begin
                        lock_digits = 0;
                        if ((lock_entry & mask) == (cfg_pin & mask)) begin
                            res.verdict = VERDICT_GRANT;
                            lock_mode   = MODE_CODE_MENU;
                        end else begin
                            res.verdict = VERDICT_WRONG;
                            if (lock_tries < TRIES_MAX)
                                lock_tries = lock_tries + 1'b1;
                            if (lock_tries >= cfg_max_tries) begin
                                lock_mode  = MODE_CODE_LOCKOUT;
                                lock_phase = '0;
                            end
                        end
                        lock_entry = '0;
                    end
                end
            end
            MODE_CODE_MENU: begin
                if (op == OP_KEY) begin
                    if (key == KEY_HASH) begin
                        acted          = 1'b1;
                        res.logged_out = 1'b1;
                        lock_mode      = MODE_CODE_STANDBY;
                        lock_phase     = '0;
                    end else if (key >= KEY_1 && key <= KEY_9) begin
                        acted           = 1'b1;
                        res.hall_toggle = HALL_W'(key - KEY_0);
                    end
                end
            end
            default: begin
                if (op == OP_TICK) begin
                    acted      = 1'b1;
                    lock_phase = lock_phase + 1'b1;
                    if (lock_phase >= ALARM_TOTAL) begin
                        lock_mode  = MODE_CODE_STANDBY;
                        lock_phase = '0;
                    end
                end
            end
        endcase
        res.mode      = lock_mode;
        res.white_led = (lock_mode == MODE_CODE_STANDBY) && (lock_phase < BLINK_ON_TICKS);
        res.green_led = (lock_mode == MODE_CODE_AUTH) || (lock_mode == MODE_CODE_MENU);
        res.red_led   = (lock_mode == MODE_CODE_LOCKOUT) &&
                        ((lock_phase % (2 * ALARM_HALF)) < ALARM_HALF);
        res.buzzer    = res.red_led;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare every result transaction with the oldest prediction.
    // ------------------------------------------------------------------
    task automatic compare_lock_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        kplc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lock_outputs.size() == 0) begin
                $error("result: expected none, actual 0x%04h", m_tdata);
                fail_count++;
            end else begin
                want = expected_lock_outputs.pop_front();
                compare_lock_field("mode",        32'(want.mode),        32'(m_tdata[1:0]));
                compare_lock_field("white_led",   32'(want.white_led),   32'(m_tdata[2]));
                compare_lock_field("green_led",   32'(want.green_led),   32'(m_tdata[3]));
                compare_lock_field("red_led",     32'(want.red_led),     32'(m_tdata[4]));
                compare_lock_field("buzzer",      32'(want.buzzer),      32'(m_tdata[5]));
                compare_lock_field("digit_taken", 32'(want.digit_taken), 32'(m_tdata[6]));
                compare_lock_field("verdict",     32'(want.verdict),     32'(m_tdata[8:7]));
                compare_lock_field("hall_toggle", 32'(want.hall_toggle), 32'(m_tdata[12:9]));
                compare_lock_field("logged_out",  32'(want.logged_out),  32'(m_tdata[13]));
                compare_lock_field("padding",     0,                     32'(m_tdata[15:14]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: mostly short ready runs and short stalls, a few long ones of each.
    // ------------------------------------------------------------------
    initial begin
        int run_len;
        int stall_len;
        wait (aresetn);
        forever begin
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
            stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
            repeat (run_len) begin
                @(negedge aclk);
                m_tready = 1'b1;
            end
            repeat (stall_len) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
        end
    end

    // Watchdog: end the run if the traffic ever stops draining.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Idle cycles ahead of the next event: usually none, sometimes a few, rarely many,
    // with occasional back-to-back bursts.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one event transaction and record the outputs it must produce.
    task automatic send_event(input logic [1:0] op, input logic [7:0] key, output bit acted);
        int unsigned  gap;
        kplc_result_t want;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = S_TDATA_W'($urandom);
            s_tuser  = OP_W'($urandom);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = key;
        s_tuser  = op;
        do @(posedge aclk); while (!s_tready);
        want = advance_lock(op, key, acted);
        expected_lock_outputs.push_back(want);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic wait_lock_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_lock_outputs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [PIN_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_PIN_CODE)
            cfg_pin = value;
        else
            cfg_max_tries = value[TRIES_W-1:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_lock_config(input logic [PIN_W-1:0] pin, input logic [TRIES_W-1:0] tries);
        wait_lock_idle();
        write_register(CFG_PIN_CODE, pin);
        write_register(CFG_MAX_ATTEMPTS, PIN_W'(tries));
    endtask

    // Pick an event that fits the current mode so sessions run deep:
    // long tick runs in standby and lockout, planned PIN entries, menu keys, some noise.
    task automatic send_session_event(output bit acted);
        int unsigned r;
        int unsigned plan;
        int unsigned miss_pos;
        logic [3:0]  nib;
        logic [1:0]  op;
        logic [7:0]  key;
        r   = $urandom_range(0, 99);
        op  = OP_KEY;
        key = 8'($urandom);
        if (lock_mode != MODE_CODE_AUTH)
            pending_digits.delete();
        if (r < 12) begin
            op = 2'($urandom_range(0, 3));
        end else begin
            case (lock_mode)
                MODE_CODE_STANDBY: begin
                    op = (r < 15) ? OP_WAKE : OP_TICK;
                end
                MODE_CODE_AUTH: begin
                    if (pending_digits.size() == 0) begin
                        // correct PIN, near miss with one digit off, or random digits
                        plan     = $urandom_range(0, 99);
                        miss_pos = $urandom_range(0, LOCK_DIGITS - 1);
                        for (int i = LOCK_DIGITS - 1; i >= 0; i--) begin
                            nib = cfg_pin[4*(i%4) +: 4];
                            if (plan >= 70 || nib > 4'd9)
                                nib = 4'($urandom_range(0, 9));
                            else if (plan >= 45 && i == int'(miss_pos))
                                nib = 4'((nib + 1 + $urandom_range(0, 8)) % 10);
                            pending_digits.push_back(KEY_0 + 8'(nib));
                        end
                    end
                    key = pending_digits.pop_front();
                end
                MODE_CODE_MENU: begin
                    if (r < 22)
                        key = KEY_HASH;
                    else if (r < 70)
                        key = KEY_0 + 8'($urandom_range(1, 9));
                    else
                        op = 2'($urandom_range(0, 3));
                end
                default: begin
                    op = OP_TICK;
                end
            endcase
        end
        send_event(op, key, acted);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: ignored events in standby, PIN entry and the menu, bad keys, a correct PIN, menu keys.
    task automatic test_directed_events();
        bit acted;
        send_event(OP_UNUSED, 8'hFF,    acted);  // unused op code
        send_event(OP_KEY,   8'h35,    acted);  // key in standby
        send_event(OP_TICK,  8'h00,    acted);
        send_event(OP_TICK,  8'hFF,    acted);
        send_event(OP_WAKE,  8'hA5,    acted);  // start PIN entry
        send_event(OP_TICK,  8'h00,    acted);  // tick while entering PIN
        send_event(OP_WAKE,  8'h00,    acted);  // second wake
        send_event(OP_KEY,   8'h41,    acted);  // 'A'
        send_event(OP_KEY,   8'h00,    acted);
        send_event(OP_KEY,   8'hFF,    acted);
        send_event(OP_KEY,   8'h2F,    acted);  // just below '0'
        send_event(OP_KEY,   8'h3A,    acted);  // just above '9'
        send_event(OP_KEY,   KEY_1,    acted);
        send_event(OP_KEY,   8'h32,    acted);
        send_event(OP_KEY,   8'h33,    acted);
        send_event(OP_KEY,   8'h34,    acted);  // completes the reset PIN
        send_event(OP_TICK,  8'h00,    acted);  // tick in the menu
        send_event(OP_WAKE,  8'h00,    acted);
        send_event(OP_UNUSED, KEY_HASH, acted);
        send_event(OP_KEY,   KEY_0,    acted);  // no hall light zero
        send_event(OP_KEY,   KEY_1,    acted);
        send_event(OP_KEY,   KEY_9,    acted);
        send_event(OP_KEY,   8'h2A,    acted);  // '*'
        send_event(OP_KEY,   KEY_HASH, acted);  // log out
    endtask

    // One attempt allowed: a wrong entry goes straight to the alarm, which runs to standby.
    task automatic test_lockout_alarm();
        bit acted;
        set_lock_config(16'h9999, 4'd1);
        send_event(OP_WAKE, 8'h00, acted);
        repeat (LOCK_DIGITS) send_event(OP_KEY, KEY_0, acted);
        send_event(OP_KEY,  KEY_HASH, acted);  // keys do nothing in lockout
        send_event(OP_WAKE, 8'h00,    acted);
        repeat (ALARM_TOTAL + 2) send_event(OP_TICK, 8'($urandom), acted);
    endtask

    // Random sessions under one register setting until enough events had an effect.
    task automatic test_random_traffic(input logic [PIN_W-1:0] pin,
                                       input logic [TRIES_W-1:0] tries,
                                       input int unsigned active_events);
        int unsigned done;
        bit          acted;
        set_lock_config(pin, tries);
        done = 0;
        while (done < active_events) begin
            send_session_event(acted);
            if (acted)
                done++;
        end
    endtask

    // Random BCD PINs with random attempt limits.
    task automatic test_random_pins(input int unsigned phases);
        logic [PIN_W-1:0] pin;
        for (int p = 0; p < int'(phases); p++) begin
            for (int i = 0; i < 4; i++)
                pin[4*i +: 4] = 4'($urandom_range(0, 9));
            test_random_traffic(pin, TRIES_W'($urandom_range(1, 15)), 330);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_events();
        test_lockout_alarm();
        test_random_traffic(16'h0000, 4'd15, 300);  // lowest PIN, most attempts
        test_random_traffic(16'h9999, 4'd1,  300);  // highest PIN, one attempt
        test_random_traffic(16'h7AF6, 4'd2,  250);  // non-BCD PIN never matches
        test_random_pins(3);

        // Hold until all results are back, then let the pipeline settle.
        wait_lock_idle();
        if (fail_count == 0 && expected_lock_outputs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kplc_pkg.sv
rtl/kplc_fsm.sv
rtl/keypad_pin_lock_controller.sv
test/keypad_pin_lock_controller_tb.sv
